@@ design/cxalu_pkg.sv @@
// cxalu_pkg: operation codes, status codes and the control word that travels along the cell row
// of the complex arithmetic unit. No dependencies.
package cxalu_pkg;

  typedef enum logic [2:0] {
    MODE_ADD  = 3'd0,
    MODE_SUB  = 3'd1,
    MODE_MUL  = 3'd2,
    MODE_DIV  = 3'd3,
    MODE_MOD  = 3'd4,
    MODE_CONJ = 3'd5
  } mode_e;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic  valid;
    mode_e mode;
    logic  pre_sat;
    logic  dz;
    logic  re_neg;
    logic  im_neg;
    logic  ovf_re;
    logic  ovf_im;
  } cell_ctrl_t;

endpackage

@@ design/cxalu_cell.sv @@
// cxalu_cell: one cell of the row; one restoring quotient bit for both divide lanes and
// one root bit for the square root lane (only when K < W), then a register. Depends on cxalu_pkg.
module cxalu_cell import cxalu_pkg::*; #(
  parameter int W = 16,
  parameter int F = 12,
  parameter int K = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  cell_ctrl_t          ctrl_i,
  input  logic [W-1:0]        pre_re_i,
  input  logic [W-1:0]        pre_im_i,
  input  logic [2*W-1:0]      den_i,
  input  logic [2*W+F-1:0]    rem_re_i,
  input  logic [2*W+F-1:0]    rem_im_i,
  input  logic [W:0]          q_re_i,
  input  logic [W:0]          q_im_i,
  input  logic [2*W-1:0]      srem_i,
  input  logic [W-1:0]        root_i,
  output cell_ctrl_t          ctrl_o,
  output logic [W-1:0]        pre_re_o,
  output logic [W-1:0]        pre_im_o,
  output logic [2*W-1:0]      den_o,
  output logic [2*W+F-1:0]    rem_re_o,
  output logic [2*W+F-1:0]    rem_im_o,
  output logic [W:0]          q_re_o,
  output logic [W:0]          q_im_o,
  output logic [2*W-1:0]      srem_o,
  output logic [W-1:0]        root_o
);

  localparam int MW = 2 * W;
  localparam int DW = 2 * W + F;
  localparam int CW = 3 * W + F + 2;
  localparam int SW = 2 * W + 1;

  logic [CW-1:0] dsh;
  logic          ge_re, ge_im;
  logic [DW-1:0] rem_re_d, rem_im_d;
  logic [W:0]    q_re_d, q_im_d;
  logic [MW-1:0] srem_d;
  logic [W-1:0]  root_d;

  cell_ctrl_t    ctrl_q;
  logic [W-1:0]  pre_re_q, pre_im_q;
  logic [MW-1:0] den_q, srem_q;
  logic [DW-1:0] rem_re_q, rem_im_q;
  logic [W:0]    q_re_q, q_im_q;
  logic [W-1:0]  root_q;

  always_comb begin
    dsh      = CW'(den_i) << K;
    ge_re    = CW'(rem_re_i) >= dsh;
    ge_im    = CW'(rem_im_i) >= dsh;
    rem_re_d = ge_re ? rem_re_i - dsh[DW-1:0] : rem_re_i;
    rem_im_d = ge_im ? rem_im_i - dsh[DW-1:0] : rem_im_i;
    q_re_d   = q_re_i | ((W+1)'(ge_re) << K);
    q_im_d   = q_im_i | ((W+1)'(ge_im) << K);
  end

  if (K < W) begin : g_root
    logic [SW-1:0] trial;
    logic          ge_s;
    always_comb begin
      trial  = (SW'(root_i) << (K + 1)) + (SW'(1) << (2 * K));
      ge_s   = SW'(srem_i) >= trial;
      srem_d = ge_s ? srem_i - trial[MW-1:0] : srem_i;
      root_d = root_i | (W'(ge_s) << K);
    end
  end else begin : g_noroot
    always_comb begin
      srem_d = srem_i;
      root_d = root_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_re_q <= pre_re_i;
      pre_im_q <= pre_im_i;
      den_q    <= den_i;
      rem_re_q <= rem_re_d;
      rem_im_q <= rem_im_d;
      q_re_q   <= q_re_d;
      q_im_q   <= q_im_d;
      srem_q   <= srem_d;
      root_q   <= root_d;
    end
  end

  assign ctrl_o   = ctrl_q;
  assign pre_re_o = pre_re_q;
  assign pre_im_o = pre_im_q;
  assign den_o    = den_q;
  assign rem_re_o = rem_re_q;
  assign rem_im_o = rem_im_q;
  assign q_re_o   = q_re_q;
  assign q_im_o   = q_im_q;
  assign srem_o   = srem_q;
  assign root_o   = root_q;

endmodule

@@ design/complex_alu_single_unit.sv @@
// complex_alu_single_unit: top level of the complex arithmetic unit; multiplier stage,
// operand stage, a row of cxalu_cell and the output register. Depends on cxalu_pkg, cxalu_cell.
//
// Usage:
//   in channel  : mode_i, a_re_i, a_im_i, b_re_i, b_im_i under in_valid_i / in_ready_o.
//   out channel : res_re_o, res_im_o, status_o under out_valid_o / out_ready_i.
//   One item is accepted per cycle while in_ready_o is high, and each item gives exactly one
//   result item, in order. From acceptance to out_valid_o an item passes one multiplier
//   stage, one stage of sums, rounding and overflow checks, DATA_WIDTH + 1 cells of the row
//   (one quotient bit per cell, one root bit per cell but the first), and the output
//   register. The row length is set by the quotient width; every mode takes the same path.
//   The whole pipeline advances together; when the receiver stalls with a result waiting,
//   in_ready_o drops and every stage holds. Reset clears all valid bits; no clearing pass.
//   Divide and modulus round toward minus infinity; all parts saturate, status reports it.
module complex_alu_single_unit import cxalu_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   mode_i,
  input  logic signed [DATA_WIDTH-1:0] a_re_i,
  input  logic signed [DATA_WIDTH-1:0] a_im_i,
  input  logic signed [DATA_WIDTH-1:0] b_re_i,
  input  logic signed [DATA_WIDTH-1:0] b_im_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] res_re_o,
  output logic signed [DATA_WIDTH-1:0] res_im_o,
  output logic [1:0]                   status_o
);

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int MW  = 2 * W;
  localparam int NW2 = 2 * W + 1;
  localparam int DW  = 2 * W + F;
  localparam int CW  = 3 * W + F + 2;
  localparam int NC  = W + 1;

  localparam logic signed [NW2-1:0] SMAX = {{(NW2-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [NW2-1:0] SMIN = {{(NW2-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic [W-1:0]          MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]          MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W+1:0]          HALF = {2'b00, 1'b1, {(W-1){1'b0}}};

  function automatic logic [W:0] sat_s(input logic signed [NW2-1:0] v);
    if (v > SMAX) begin
      return {1'b1, MAXV};
    end else if (v < SMIN) begin
      return {1'b1, MINV};
    end
    return {1'b0, v[W-1:0]};
  endfunction

  function automatic logic [W:0] div_fin(input logic neg, input logic [W:0] q,
                                         input logic rnz, input logic ovf);
    logic [W+1:0] mag;
    logic [W+1:0] nm;
    mag = {1'b0, q} + (W+2)'(neg && rnz);
    nm  = -mag;
    if (ovf) begin
      return neg ? {1'b1, MINV} : {1'b1, MAXV};
    end else if (!neg) begin
      if (mag > HALF - 1) begin
        return {1'b1, MAXV};
      end
      return {1'b0, mag[W-1:0]};
    end else if (mag > HALF) begin
      return {1'b1, MINV};
    end
    return {1'b0, nm[W-1:0]};
  endfunction

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // multiplier stage
  logic                 a_valid_q;
  mode_e                a_mode_q;
  logic signed [W-1:0]  ar_q, ai_q, br_q, bi_q;
  logic signed [MW-1:0] m0_q, m1_q, m2_q, m3_q, m4_q, m5_q;
  logic signed [W-1:0]  y0, y1;

  always_comb begin
    y0 = (mode_e'(mode_i) == MODE_MOD) ? a_re_i : b_re_i;
    y1 = (mode_e'(mode_i) == MODE_MOD) ? a_im_i : b_im_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_mode_q <= mode_e'(mode_i);
      ar_q     <= a_re_i;
      ai_q     <= a_im_i;
      br_q     <= b_re_i;
      bi_q     <= b_im_i;
      m0_q     <= MW'(a_re_i) * MW'(y0);
      m1_q     <= MW'(a_im_i) * MW'(y1);
      m2_q     <= MW'(a_re_i) * MW'(b_im_i);
      m3_q     <= MW'(a_im_i) * MW'(b_re_i);
      m4_q     <= MW'(b_re_i) * MW'(b_re_i);
      m5_q     <= MW'(b_im_i) * MW'(b_im_i);
    end
  end

  // operand stage
  logic signed [NW2-1:0] s_re, s_im, n_re, n_im;
  logic [W:0]            sat_re, sat_im;
  logic [MW-1:0]         mag_re, mag_im, den, sq;
  logic [DW-1:0]         d_re, d_im;
  cell_ctrl_t            b_ctrl;

  always_comb begin
    s_re = '0;
    s_im = '0;
    unique case (a_mode_q)
      MODE_ADD: begin
        s_re = NW2'(ar_q) + NW2'(br_q);
        s_im = NW2'(ai_q) + NW2'(bi_q);
      end
      MODE_SUB: begin
        s_re = NW2'(ar_q) - NW2'(br_q);
        s_im = NW2'(ai_q) - NW2'(bi_q);
      end
      MODE_MUL: begin
        s_re = (NW2'(m0_q) - NW2'(m1_q)) >>> F;
        s_im = (NW2'(m2_q) + NW2'(m3_q)) >>> F;
      end
      MODE_CONJ: begin
        s_re = NW2'(ar_q);
        s_im = -NW2'(ai_q);
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
    sat_re = sat_s(s_re);
    sat_im = sat_s(s_im);

    n_re   = NW2'(m0_q) + NW2'(m1_q);
    n_im   = NW2'(m3_q) - NW2'(m2_q);
    mag_re = n_re[NW2-1] ? MW'(-n_re) : MW'(n_re);
    mag_im = n_im[NW2-1] ? MW'(-n_im) : MW'(n_im);
    den    = unsigned'(m4_q) + unsigned'(m5_q);
    sq     = unsigned'(m0_q) + unsigned'(m1_q);
    d_re   = {mag_re, {F{1'b0}}};
    d_im   = {mag_im, {F{1'b0}}};

    b_ctrl.valid   = a_valid_q;
    b_ctrl.mode    = a_mode_q;
    b_ctrl.pre_sat = sat_re[W] || sat_im[W];
    b_ctrl.dz      = (den == '0);
    b_ctrl.re_neg  = n_re[NW2-1];
    b_ctrl.im_neg  = n_im[NW2-1];
    b_ctrl.ovf_re  = CW'(d_re) >= (CW'(den) << (W + 1));
    b_ctrl.ovf_im  = CW'(d_im) >= (CW'(den) << (W + 1));
  end

  cell_ctrl_t    ctrl_c   [NC+1];
  logic [W-1:0]  pre_re_c [NC+1];
  logic [W-1:0]  pre_im_c [NC+1];
  logic [MW-1:0] den_c    [NC+1];
  logic [DW-1:0] rem_re_c [NC+1];
  logic [DW-1:0] rem_im_c [NC+1];
  logic [W:0]    q_re_c   [NC+1];
  logic [W:0]    q_im_c   [NC+1];
  logic [MW-1:0] srem_c   [NC+1];
  logic [W-1:0]  root_c   [NC+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_c[0] <= '0;
    end else if (en) begin
      ctrl_c[0] <= b_ctrl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pre_re_c[0] <= sat_re[W-1:0];
      pre_im_c[0] <= sat_im[W-1:0];
      den_c[0]    <= den;
      rem_re_c[0] <= d_re;
      rem_im_c[0] <= d_im;
      q_re_c[0]   <= '0;
      q_im_c[0]   <= '0;
      srem_c[0]   <= sq;
      root_c[0]   <= '0;
    end
  end

  for (genvar j = 0; j < NC; j++) begin : g_row
    cxalu_cell #(.W(W), .F(F), .K(W - j)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .ctrl_i   (ctrl_c[j]),
      .pre_re_i (pre_re_c[j]),
      .pre_im_i (pre_im_c[j]),
      .den_i    (den_c[j]),
      .rem_re_i (rem_re_c[j]),
      .rem_im_i (rem_im_c[j]),
      .q_re_i   (q_re_c[j]),
      .q_im_i   (q_im_c[j]),
      .srem_i   (srem_c[j]),
      .root_i   (root_c[j]),
      .ctrl_o   (ctrl_c[j+1]),
      .pre_re_o (pre_re_c[j+1]),
      .pre_im_o (pre_im_c[j+1]),
      .den_o    (den_c[j+1]),
      .rem_re_o (rem_re_c[j+1]),
      .rem_im_o (rem_im_c[j+1]),
      .q_re_o   (q_re_c[j+1]),
      .q_im_o   (q_im_c[j+1]),
      .srem_o   (srem_c[j+1]),
      .root_o   (root_c[j+1])
    );
  end

  // output stage
  cell_ctrl_t   lc;
  logic [W:0]   f_re, f_im;
  logic [W-1:0] res_re_d, res_im_d;
  logic [1:0]   status_d;
  logic [W-1:0] res_re_q, res_im_q;
  logic [1:0]   status_q;

  always_comb begin
    lc       = ctrl_c[NC];
    f_re     = div_fin(lc.re_neg, q_re_c[NC], rem_re_c[NC] != '0, lc.ovf_re);
    f_im     = div_fin(lc.im_neg, q_im_c[NC], rem_im_c[NC] != '0, lc.ovf_im);
    res_re_d = pre_re_c[NC];
    res_im_d = pre_im_c[NC];
    status_d = lc.pre_sat ? ST_SAT : ST_OK;
    unique case (lc.mode)
      MODE_DIV: begin
        if (lc.dz) begin
          res_re_d = '0;
          res_im_d = '0;
          status_d = ST_DZ;
        end else begin
          res_re_d = f_re[W-1:0];
          res_im_d = f_im[W-1:0];
          status_d = (f_re[W] || f_im[W]) ? ST_SAT : ST_OK;
        end
      end
      MODE_MOD: begin
        res_im_d = '0;
        if (root_c[NC] > MAXV) begin
          res_re_d = MAXV;
          status_d = ST_SAT;
        end else begin
          res_re_d = root_c[NC];
          status_d = ST_OK;
        end
      end
      default: begin
        res_re_d = pre_re_c[NC];
        res_im_d = pre_im_c[NC];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= lc.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_re_o    = signed'(res_re_q);
  assign res_im_o    = signed'(res_im_q);
  assign status_o    = status_q;

endmodule

@@ design/cxalu_chk.sv @@
// cxalu_chk: port-level checks of the complex arithmetic unit, bound to the top level.
// Depends on cxalu_pkg and complex_alu_single_unit.
module cxalu_chk import cxalu_pkg::*; #(
  parameter int DATA_WIDTH = 16
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic signed [DATA_WIDTH-1:0] res_re_o,
  input logic signed [DATA_WIDTH-1:0] res_im_o,
  input logic [1:0]                   status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_re_o) && $stable(res_im_o)
      && $stable(status_o))
    else $error("result changed while stalled");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("input item withdrawn while stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with output register empty");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_SAT || status_o == ST_DZ)
    else $error("undefined status code");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_DZ |-> res_re_o == '0 && res_im_o == '0)
    else $error("divide by zero with nonzero result");

endmodule

bind complex_alu_single_unit cxalu_chk #(.DATA_WIDTH(DATA_WIDTH)) u_cxalu_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .res_re_o    (res_re_o),
  .res_im_o    (res_im_o),
  .status_o    (status_o)
);
